### rtl/ckr_pkg.sv
// Shared types, constants and word tables for the command keyword recognizer.
package ckr_pkg;

    localparam int WORD_COUNT = 3;

    localparam logic [7:0] ABORT_BYTE  = 8'h03;
    localparam logic [3:0] LIMIT_RESET = 4'd3;

    typedef enum logic [2:0] {
        KIND_UPTIME  = 3'd0,
        KIND_LOAD    = 3'd1,
        KIND_EXIT    = 3'd2,
        KIND_INVALID = 3'd3,
        KIND_ABORT   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        WORD_UPTIME = 2'd0,
        WORD_LOAD   = 2'd1,
        WORD_EXIT   = 2'd2
    } t_word;

    typedef struct packed {
        logic [2:0] match_position;
        logic [2:0] word_alive;     // bit 0 uptime, bit 1 load, bit 2 exit
        logic [3:0] invalid_run;
    } t_state;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  end_session;
    } t_result;

    localparam t_state STATE_RESET = '{
        match_position: 3'd0,
        word_alive:     3'b111,
        invalid_run:    4'd0
    };

    function automatic logic [3:0] word_len(input logic [1:0] k);
        logic [3:0] len;
        case (k)
            WORD_UPTIME: len = 4'd6;
            WORD_LOAD:   len = 4'd4;
            WORD_EXIT:   len = 4'd4;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            WORD_UPTIME: begin
                case (pos)
                    3'd0:    ch = "u";
                    3'd1:    ch = "p";
                    3'd2:    ch = "t";
                    3'd3:    ch = "i";
                    3'd4:    ch = "m";
                    3'd5:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            WORD_LOAD: begin
                case (pos)
                    3'd0:    ch = "l";
                    3'd1:    ch = "o";
                    3'd2:    ch = "a";
                    3'd3:    ch = "d";
                    default: ch = 8'h00;
                endcase
            end
            WORD_EXIT: begin
                case (pos)
                    3'd0:    ch = "e";
                    3'd1:    ch = "x";
                    3'd2:    ch = "i";
                    3'd3:    ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/command_keyword_recognizer.sv
// Top level of the command keyword recognizer: input register, matcher, result register.
//
//   channel  direction  handshake               payload
//   in       sink       i_in_valid/o_in_stall   i_byte_in
//   out      source     o_out_valid/i_out_stall o_request_kind, o_end_session
//   cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_invalid_limit
//
// One byte per cycle sustained while the result is not stalled; a byte that yields a result
// passes through the input register, then the matcher into the result register.
// Match state updates as a byte leaves the input register, which happens only while
// the result register is empty or its beat is taken in the same cycle.
// A stalled result holds the byte in the input register; o_in_stall stays high until
// the result is taken. Synchronous active-low reset clears match state and valid flags, limit 3.
module command_keyword_recognizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_request_kind,
    output logic       o_end_session,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_invalid_limit
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    ckr_pkg::t_state   r_state;
    ckr_pkg::t_state   n_state;
    ckr_pkg::t_result  n_result;
    logic [3:0]        r_limit;
    logic              r_out_valid;
    ckr_pkg::t_kind    r_out_kind;
    logic              r_out_end;
    logic              in_accept;
    logic              advance;

    // byte leaves the input register when the result register can take a beat
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    ckr_match u_match (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .i_limit  (r_limit),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= ckr_pkg::STATE_RESET;
            r_limit     <= ckr_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_invalid_limit;
            end
            if (advance && n_result.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_byte_in;
        end
        if (advance && n_result.valid) begin
            r_out_kind <= n_result.kind;
            r_out_end  <= n_result.end_session;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_request_kind = r_out_kind;
    assign o_end_session  = r_out_end;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.valid && n_result.end_session
        |=> r_state == ckr_pkg::STATE_RESET)
        else $error("session end did not clear match state");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.match_position <= 3'd5)
        else $error("match position past longest word");

    a_alive_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.word_alive != 3'b000)
        else $error("no word possible but match not restarted");

    a_abort_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_request_kind == ckr_pkg::KIND_ABORT
                        || o_request_kind == ckr_pkg::KIND_EXIT)
        |-> o_end_session)
        else $error("abort or exit without session end");

endmodule

### rtl/ckr_match.sv
// Next-state and result logic for one received byte.
module ckr_match (
    input  logic [7:0]      i_byte,
    input  ckr_pkg::t_state i_state,
    input  logic [3:0]      i_limit,
    output ckr_pkg::t_state o_state,
    output ckr_pkg::t_result o_result
);

    logic [2:0] alive;
    logic [2:0] hit;
    logic [3:0] lim_eff;
    logic [3:0] run;

    always_comb begin
        alive = '0;
        hit   = '0;
        for (int k = 0; k < ckr_pkg::WORD_COUNT; k++) begin
            if (i_state.word_alive[k] && i_byte != 8'h00
                && ({1'b0, i_state.match_position} < ckr_pkg::word_len(2'(k)))
                && ckr_pkg::word_char(2'(k), i_state.match_position) == i_byte) begin
                alive[k] = 1'b1;
            end
            if (alive[k] && ({1'b0, i_state.match_position} + 4'd1
                             == ckr_pkg::word_len(2'(k)))) begin
                hit[k] = 1'b1;
            end
        end
    end

    // a limit of zero behaves as one
    assign lim_eff = (i_limit == 4'd0) ? 4'd1 : i_limit;
    assign run     = i_state.invalid_run + 4'd1;

    always_comb begin
        o_state                = i_state;
        o_result.valid         = 1'b0;
        o_result.kind          = ckr_pkg::KIND_INVALID;
        o_result.end_session   = 1'b0;
        if (i_byte == ckr_pkg::ABORT_BYTE) begin
            o_state              = ckr_pkg::STATE_RESET;
            o_result.valid       = 1'b1;
            o_result.kind        = ckr_pkg::KIND_ABORT;
            o_result.end_session = 1'b1;
        end else if (hit[ckr_pkg::WORD_UPTIME]) begin
            o_state        = ckr_pkg::STATE_RESET;
            o_result.valid = 1'b1;
            o_result.kind  = ckr_pkg::KIND_UPTIME;
        end else if (hit[ckr_pkg::WORD_LOAD]) begin
            o_state        = ckr_pkg::STATE_RESET;
            o_result.valid = 1'b1;
            o_result.kind  = ckr_pkg::KIND_LOAD;
        end else if (hit[ckr_pkg::WORD_EXIT]) begin
            o_state              = ckr_pkg::STATE_RESET;
            o_result.valid       = 1'b1;
            o_result.kind        = ckr_pkg::KIND_EXIT;
            o_result.end_session = 1'b1;
        end else if (alive == 3'b000) begin
            o_result.valid = 1'b1;
            o_result.kind  = ckr_pkg::KIND_INVALID;
            o_state        = ckr_pkg::STATE_RESET;
            if (run >= lim_eff) begin
                o_result.end_session = 1'b1;
            end else begin
                o_state.invalid_run = run;
            end
        end else begin
            o_state.word_alive     = alive;
            o_state.match_position = i_state.match_position + 3'd1;
        end
    end

endmodule

### test/tb.sv
// Self-checking testbench for command_keyword_recognizer: directed script, random traffic, limits.
module tb;

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 6;     // pipeline is two stages deep
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 255;
    localparam int SCRIPT_LEN     = 24;

    typedef struct packed {
        ckr_pkg::t_kind kind;
        logic           closes;
    } t_reply;

    typedef struct packed {
        logic [7:0]     ch;
        logic           typed;     // kind/closes below hold only when typed is set
        ckr_pkg::t_kind kind;
        logic           closes;
    } t_script_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_byte_in;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_request_kind;
    logic       o_end_session;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_invalid_limit;

    // typed-in expectation travels with the beat
    logic           beat_typed;
    ckr_pkg::t_kind beat_kind;
    logic           beat_closes;

    // matcher state kept by the testbench
    logic [2:0] sess_pos;
    logic [2:0] sess_alive;
    logic [3:0] sess_invalid_run;
    logic [3:0] sess_limit;

    t_reply     expected_replies[$];
    logic [7:0] planned_bytes[$];

    int  mismatches;
    int  bytes_accepted;
    int  results_checked;
    int  sessions_closed;
    int  kind_count[5];
    int  idle_cycles;
    bit  no_idling;
    bit  hold_off_req;
    bit  burst_on;

    t_script_row script[SCRIPT_LEN] = '{
        '{"u",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"p",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"t",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"i",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"m",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"e",   1'b1, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"l",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"o",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"a",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"d",   1'b1, ckr_pkg::KIND_LOAD,    1'b0},
        '{8'h00, 1'b1, ckr_pkg::KIND_INVALID, 1'b0},   // NUL matches nothing
        '{8'hFF, 1'b1, ckr_pkg::KIND_INVALID, 1'b0},
        '{"e",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"x",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{8'h03, 1'b1, ckr_pkg::KIND_ABORT,   1'b1},   // abort mid-word
        '{"x",   1'b1, ckr_pkg::KIND_INVALID, 1'b0},
        '{"u",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"q",   1'b1, ckr_pkg::KIND_INVALID, 1'b0},
        '{8'h80, 1'b1, ckr_pkg::KIND_INVALID, 1'b1},   // third invalid in a row hits the limit
        '{"e",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"x",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"i",   1'b0, ckr_pkg::KIND_UPTIME,  1'b0},
        '{"t",   1'b1, ckr_pkg::KIND_EXIT,    1'b1},
        '{8'h03, 1'b1, ckr_pkg::KIND_ABORT,   1'b1}    // abort at position zero
    };

    command_keyword_recognizer u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_byte_in           (i_byte_in),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_request_kind      (o_request_kind),
        .o_end_session       (o_end_session),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_invalid_limit (i_cfg_invalid_limit)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int kw_len(input int w);
        return (w == 0) ? 6 : 4;
    endfunction

    function automatic logic [7:0] kw_char(input int w, input int p);
        logic [47:0] txt;
        txt = (w == 0) ? "uptime" : (w == 1) ? {"load", 16'h0} : {"exit", 16'h0};
        return txt[47 - 8 * p -: 8];
    endfunction

    // Advances the matcher by one byte; returns 1 when the byte yields a reply.
    function automatic bit recognize_byte(input logic [7:0] b, output t_reply rep);
        logic [2:0] hit;
        logic [3:0] lim;
        logic [3:0] run;
        int         w;
        hit = 3'b000;
        rep = '{ckr_pkg::KIND_UPTIME, 1'b0};
        if (b == ckr_pkg::ABORT_BYTE) begin
            sess_pos = 3'd0;
            sess_alive = 3'b111;
            sess_invalid_run = 4'd0;
            rep = '{ckr_pkg::KIND_ABORT, 1'b1};
            return 1'b1;
        end
        for (w = 0; w < 3; w++) begin
            if (sess_alive[w] && int'(sess_pos) < kw_len(w) && b != 8'h00
                    && kw_char(w, int'(sess_pos)) == b)
                hit[w] = 1'b1;
        end
        for (w = 0; w < 3; w++) begin
            if (hit[w] && int'(sess_pos) + 1 == kw_len(w)) begin
                sess_pos = 3'd0;
                sess_alive = 3'b111;
                sess_invalid_run = 4'd0;
                if (w == 2)
                    rep = '{ckr_pkg::KIND_EXIT, 1'b1};
                else
                    rep = '{(w == 0) ? ckr_pkg::KIND_UPTIME : ckr_pkg::KIND_LOAD, 1'b0};
                return 1'b1;
            end
        end
        if (hit == 3'b000) begin
            lim = (sess_limit == 4'd0) ? 4'd1 : sess_limit;
            run = sess_invalid_run + 4'd1;
            sess_pos = 3'd0;
            sess_alive = 3'b111;
            if (run >= lim) begin
                sess_invalid_run = 4'd0;
                rep = '{ckr_pkg::KIND_INVALID, 1'b1};
            end else begin
                sess_invalid_run = run;
                rep = '{ckr_pkg::KIND_INVALID, 1'b0};
            end
            return 1'b1;
        end
        sess_alive = hit;
        sess_pos = sess_pos + 3'd1;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    // result check first, then the byte accepted at the same edge
    always @(posedge i_clk) begin : scoreboard
        t_reply want;
        t_reply pred;
        bit     has_reply;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("result with nothing expected", o_request_kind, -1);
                end else begin
                    want = expected_replies.pop_front();
                    if (o_request_kind !== want.kind)
                        report_mismatch("request_kind", o_request_kind, want.kind);
                    if (o_end_session !== want.closes)
                        report_mismatch("end_session", o_end_session, want.closes);
                end
                if (o_request_kind <= ckr_pkg::KIND_ABORT)
                    kind_count[o_request_kind]++;
                if (o_end_session === 1'b1)
                    sessions_closed++;
                results_checked++;
            end
            if (i_in_valid && !o_in_stall) begin
                has_reply = recognize_byte(i_byte_in, pred);
                if (beat_typed)
                    expected_replies.push_back(t_reply'{beat_kind, beat_closes});
                else if (has_reply)
                    expected_replies.push_back(pred);
                bytes_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_replies.size());
            $display("FAIL command_keyword_recognizer");
            $finish;
        end
    end

    // receiver: random stall bursts, a long hold-off on request
    initial begin : receiver
        bit held;
        held = 1'b0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req && !held) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else if (!no_idling && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic drive_byte(input logic [7:0] b, input logic typed, input ckr_pkg::t_kind k,
                              input logic closes);
        i_in_valid  <= 1'b1;
        i_byte_in   <= b;
        beat_typed  <= typed;
        beat_kind   <= k;
        beat_closes <= closes;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic idle_gap(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // sender stops until every expected result is back, then lets the pipe empty
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [3:0] v);
        i_cfg_valid         <= 1'b1;
        i_cfg_invalid_limit <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sess_limit = v;
    endtask

    // well-formed words in 45 of 100 picks; the rest broken prefixes, invalid runs, aborts and single random bytes
    task automatic plan_sequence();
        int pick;
        int w;
        int n;
        int p;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            w = (pick < 20) ? 0 : (pick < 38) ? 1 : 2;
            for (p = 0; p < kw_len(w); p++)
                planned_bytes.push_back(kw_char(w, p));
        end else if (pick < 65) begin
            w = $urandom_range(0, 2);
            n = $urandom_range(1, kw_len(w) - 1);
            for (p = 0; p < n; p++)
                planned_bytes.push_back(kw_char(w, p));
            case ($urandom_range(0, 3))
                0:       planned_bytes.push_back(8'h00);
                1:       planned_bytes.push_back(ckr_pkg::ABORT_BYTE);
                default: planned_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end else if (pick < 85) begin
            n = $urandom_range(1, 16);
            repeat (n) planned_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 90) begin
            planned_bytes.push_back(ckr_pkg::ABORT_BYTE);
        end else begin
            planned_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int         k;
        int         ph;
        int         sent;
        bit         paused;
        bit         hold_done;
        logic [3:0] lim;
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_byte_in           <= 8'h00;
        i_cfg_valid         <= 1'b0;
        i_cfg_invalid_limit <= 4'd0;
        beat_typed          <= 1'b0;
        beat_kind           <= ckr_pkg::KIND_UPTIME;
        beat_closes         <= 1'b0;
        sess_pos         = 3'd0;
        sess_alive       = 3'b111;
        sess_invalid_run = 4'd0;
        sess_limit       = ckr_pkg::LIMIT_RESET;
        hold_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < SCRIPT_LEN; k++) begin
            if ($urandom_range(0, 5) == 0)
                idle_gap($urandom_range(1, 10));
            drive_byte(script[k].ch, script[k].typed, script[k].kind, script[k].closes);
        end

        for (ph = 0; ph < 6; ph++) begin
            settle_pipeline();
            case (ph)
                0:       lim = 4'd15;
                1:       lim = 4'd1;
                2:       lim = 4'd0;
                3:       lim = 4'd2;
                4:       lim = 4'($urandom_range(4, 14));
                default: lim = ckr_pkg::LIMIT_RESET;
            endcase
            write_limit(lim);
            no_idling = (ph == 5);
            paused = no_idling;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (ph == 1 && sent >= 60 && !hold_done) begin
                    hold_off_req = 1'b1;
                    burst_on = 1'b1;
                    hold_done = 1'b1;
                end
                if (burst_on && sent >= 100)
                    burst_on = 1'b0;
                if (!paused && sent >= PHASE_ITEMS / 2) begin
                    settle_pipeline();
                    paused = 1'b1;
                end
                plan_sequence();
                while (planned_bytes.size() != 0) begin
                    if (!no_idling && !burst_on && $urandom_range(0, 9) == 0)
                        idle_gap($urandom_range(1, 10));
                    drive_byte(planned_bytes.pop_front(), 1'b0, ckr_pkg::KIND_UPTIME, 1'b0);
                    sent++;
                end
            end
        end

        settle_pipeline();
        $display("covered %0d bytes, %0d results: uptime %0d, load %0d, exit %0d,",
                 bytes_accepted, results_checked, kind_count[0], kind_count[1],
                 kind_count[2]);
        $display("invalid %0d, abort %0d; limits 0, 1, 2, 3, 15 and one random;",
                 kind_count[3], kind_count[4]);
        $display("%0d sessions closed, %0d mismatches", sessions_closed, mismatches);
        if (mismatches == 0)
            $display("PASS command_keyword_recognizer");
        else
            $display("FAIL command_keyword_recognizer");
        $finish;
    end

endmodule

### command_keyword_recognizer.f
rtl/ckr_pkg.sv
rtl/ckr_match.sv
rtl/command_keyword_recognizer.sv
test/tb.sv
